### hdl/forth_data_stack_unit_macros.svh
// Assertion macros shared by the data stack RTL.
`ifndef FORTH_DATA_STACK_UNIT_MACROS_SVH
`define FORTH_DATA_STACK_UNIT_MACROS_SVH

// Clocked check that is ignored while reset is held.
`define FDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define FDS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/fds_pkg.sv
// Package with item types, action and status codes and action tables for the data stack.
package fds_pkg;

  localparam int WORD_BITS = 32;
  localparam int DEFAULT_DEPTH = 64;
  localparam logic [6:0] CAP_RESET = 7'd64;

  localparam logic [4:0] ACT_PUSH   = 5'd0;
  localparam logic [4:0] ACT_POP    = 5'd1;
  localparam logic [4:0] ACT_TOP    = 5'd2;
  localparam logic [4:0] ACT_DUP    = 5'd3;
  localparam logic [4:0] ACT_SWAP   = 5'd4;
  localparam logic [4:0] ACT_DROP   = 5'd5;
  localparam logic [4:0] ACT_OVER   = 5'd6;
  localparam logic [4:0] ACT_ROT    = 5'd7;
  localparam logic [4:0] ACT_2SWAP  = 5'd8;
  localparam logic [4:0] ACT_2DUP   = 5'd9;
  localparam logic [4:0] ACT_2OVER  = 5'd10;
  localparam logic [4:0] ACT_2DROP  = 5'd11;
  localparam logic [4:0] ACT_ADD    = 5'd12;
  localparam logic [4:0] ACT_SUB    = 5'd13;
  localparam logic [4:0] ACT_MUL    = 5'd14;
  localparam logic [4:0] ACT_DIV    = 5'd15;
  localparam logic [4:0] ACT_EQ     = 5'd16;
  localparam logic [4:0] ACT_LT     = 5'd17;
  localparam logic [4:0] ACT_GT     = 5'd18;

  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_FEW  = 2'd1;
  localparam logic [1:0] STS_FULL = 2'd2;
  localparam logic [1:0] STS_DIV0 = 2'd3;

  typedef struct packed {
    logic [4:0]                  action;
    logic signed [WORD_BITS-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic signed [WORD_BITS-1:0] result_value;
    logic [6:0]                  depth;
  } out_item_t;

  // Number of entries an action consumes from the top.
  function automatic logic [2:0] act_need(input logic [4:0] act);
    logic [2:0] n;
    begin
      unique case (act)
        ACT_PUSH: n = 3'd0;
        ACT_POP, ACT_TOP, ACT_DUP, ACT_DROP: n = 3'd1;
        ACT_ROT: n = 3'd3;
        ACT_2SWAP, ACT_2OVER: n = 3'd4;
        default: n = 3'd2;
      endcase
      return n;
    end
  endfunction

  // Net growth of actions that add entries, zero for all others.
  function automatic logic [1:0] act_add(input logic [4:0] act);
    logic [1:0] g;
    begin
      unique case (act)
        ACT_PUSH, ACT_DUP, ACT_OVER: g = 2'd1;
        ACT_2DUP, ACT_2OVER: g = 2'd2;
        default: g = 2'd0;
      endcase
      return g;
    end
  endfunction

endpackage

### hdl/forth_data_stack_unit.sv
// Bounded Forth data stack with stack memory, operand sequencer and iterative divider.
//
// The input channel (in_valid, in_stall, in_data) takes one action item: push, pop,
// stack shuffles, arithmetic or comparisons on signed words. Each item yields exactly
// one result item on (out_valid, out_stall, out_data): status, the popped or top word,
// and the depth afterwards. The cfg channel writes the capacity limit; cfg_ready is
// always high and writes belong in idle periods.
// An item runs as a sequence over one single-port stack memory: a check step, a read of
// each operand (up to four) and a closing read step, a compute step, a write of each
// word pushed back (up to six) and a closing write step, an optional top-of-stack read
// (ST_TOPRD, ST_TOPWT), and a hand-off to the output register. A divide runs the
// restoring divider between the compute and write steps. One item is in work at a time,
// so the next item is taken the cycle after the hand-off.
// A result that is stalled waits in the output register; the next item may be taken
// in the meantime and waits for that register to drain before delivering.
// Synchronous reset empties the stack and sets capacity to 64; the memory is not
// cleared, since entries above the count are never used.
module forth_data_stack_unit #(
  parameter int DEPTH = fds_pkg::DEFAULT_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  fds_pkg::in_item_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output fds_pkg::out_item_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [6:0]       cfg_data
);
  import fds_pkg::*;

  `include "forth_data_stack_unit_macros.svh"

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int DCW = $clog2(WORD_BITS + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHK   = 4'd1;
  localparam logic [3:0] ST_READ  = 4'd2;
  localparam logic [3:0] ST_CALC  = 4'd3;
  localparam logic [3:0] ST_DIV   = 4'd4;
  localparam logic [3:0] ST_WRITE = 4'd5;
  localparam logic [3:0] ST_TOPRD = 4'd6;
  localparam logic [3:0] ST_TOPWT = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [3:0]                  state_r;
  logic [4:0]                  act_r;
  logic signed [WORD_BITS-1:0] pv_r;
  logic [CW-1:0]               cnt_r;
  logic [CW-1:0]               base_r;
  logic [2:0]                  need_r;
  logic [2:0]                  nr_r;
  logic [2:0]                  idx_r;
  logic                        rdv_r;
  logic [1:0]                  rdi_r;
  logic signed [WORD_BITS-1:0] t_r [4];
  logic signed [WORD_BITS-1:0] r_r [6];
  logic [1:0]                  sts_r;
  logic signed [WORD_BITS-1:0] res_r;
  logic [6:0]                  cap_r;
  logic                        out_valid_r;
  out_item_t                   out_data_r;

  // Stack memory with registered read data.
  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] mem_q_r;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 we;
  logic [CW-1:0]        wr_full;
  logic [WORD_BITS-1:0] wr_data;

  // Divider registers.
  logic [WORD_BITS-1:0] rem_r;
  logic [WORD_BITS-1:0] quo_r;
  logic [WORD_BITS-1:0] dvs_r;
  logic [DCW-1:0]       dcnt_r;
  logic                 dneg_r;
  logic [WORD_BITS:0]   rem_sh;
  logic [WORD_BITS:0]   rem_diff;

  // Check and compute helpers.
  logic [2:0]                  need_c;
  logic [1:0]                  add_c;
  logic [CW:0]                 cap_eff;
  logic [CW:0]                 grow_sum;
  logic signed [WORD_BITS-1:0] rc [6];
  logic [2:0]                  nr_c;
  logic signed [WORD_BITS-1:0] prod_c;
  logic signed [WORD_BITS-1:0] true_w;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign true_w    = '1;

  assign need_c   = act_need(act_r);
  assign add_c    = act_add(act_r);
  assign cap_eff  = (cap_r < DEPTH) ? (CW+1)'(cap_r) : (CW+1)'(DEPTH);
  assign grow_sum = (CW+1)'(cnt_r) + (CW+1)'(add_c);
  assign prod_c   = WORD_BITS'(t_r[1] * t_r[0]);

  // One restoring divide step on magnitudes.
  assign rem_sh   = {rem_r, quo_r[WORD_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};

  // Memory access decode from the sequencer state.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(cnt_r - CW'(1));
    we      = 1'b0;
    wr_full = base_r + CW'(idx_r);
    wr_data = r_r[idx_r];
    if (state_r == ST_READ && idx_r < need_r) begin
      rd_en   = 1'b1;
      rd_addr = AW'(cnt_r - CW'(1) - CW'(idx_r));
    end else if (state_r == ST_TOPRD) begin
      rd_en = 1'b1;
    end
    if (state_r == ST_WRITE && idx_r < nr_r) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[AW'(wr_full)] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // New words for each action, written back from the lowest entry upward.
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      rc[i] = t_r[0];
    end
    nr_c = 3'd1;
    case (act_r)
      ACT_PUSH: rc[0] = pv_r;
      ACT_POP, ACT_DROP, ACT_2DROP: nr_c = 3'd0;
      ACT_TOP: rc[0] = t_r[0];
      ACT_DUP: nr_c = 3'd2;
      ACT_SWAP: begin
        rc[1] = t_r[1];
        nr_c  = 3'd2;
      end
      ACT_OVER: begin
        rc[0] = t_r[1];
        rc[2] = t_r[1];
        nr_c  = 3'd3;
      end
      ACT_ROT: begin
        rc[0] = t_r[1];
        rc[2] = t_r[2];
        nr_c  = 3'd3;
      end
      ACT_2SWAP: begin
        rc[0] = t_r[1];
        rc[2] = t_r[3];
        rc[3] = t_r[2];
        nr_c  = 3'd4;
      end
      ACT_2DUP: begin
        rc[0] = t_r[1];
        rc[2] = t_r[1];
        nr_c  = 3'd4;
      end
      ACT_2OVER: begin
        rc[0] = t_r[3];
        rc[1] = t_r[2];
        rc[2] = t_r[1];
        rc[4] = t_r[3];
        rc[5] = t_r[2];
        nr_c  = 3'd6;
      end
      ACT_ADD: rc[0] = t_r[1] + t_r[0];
      ACT_SUB: rc[0] = t_r[1] - t_r[0];
      ACT_MUL: rc[0] = prod_c;
      ACT_EQ:  rc[0] = (t_r[1] == t_r[0]) ? true_w : '0;
      ACT_LT:  rc[0] = (t_r[1] < t_r[0]) ? true_w : '0;
      default: rc[0] = (t_r[0] < t_r[1]) ? true_w : '0;
    endcase
  end

  // Sequencer, operand capture, divider and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
      rdv_r       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (out_valid_r && !out_stall && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      // Read data arrives in the cycle after each operand read.
      rdv_r <= (state_r == ST_READ) && (idx_r < need_r);
      if (rdv_r) begin
        t_r[rdi_r] <= mem_q_r;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            act_r   <= in_data.action;
            pv_r    <= in_data.push_value;
            state_r <= ST_CHK;
          end
        end
        ST_CHK: begin
          need_r  <= need_c;
          idx_r   <= '0;
          base_r  <= cnt_r - CW'(need_c);
          if (act_r > ACT_GT) begin
            sts_r   <= STS_OK;
            state_r <= ST_TOPRD;
          end else if (cnt_r < CW'(need_c)) begin
            sts_r   <= STS_FEW;
            state_r <= ST_TOPRD;
          end else if (add_c != 2'd0 && grow_sum > cap_eff) begin
            sts_r   <= STS_FULL;
            state_r <= ST_TOPRD;
          end else begin
            sts_r   <= STS_OK;
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          if (idx_r < need_r) begin
            rdi_r <= idx_r[1:0];
            idx_r <= idx_r + 3'd1;
          end else begin
            state_r <= ST_CALC;
          end
        end
        ST_CALC: begin
          idx_r <= '0;
          res_r <= t_r[0];
          if (act_r == ACT_DIV && t_r[0] == '0) begin
            sts_r   <= STS_DIV0;
            state_r <= ST_TOPRD;
          end else if (act_r == ACT_DIV) begin
            dvs_r   <= t_r[0][WORD_BITS-1] ? -t_r[0] : t_r[0];
            quo_r   <= t_r[1][WORD_BITS-1] ? -t_r[1] : t_r[1];
            rem_r   <= '0;
            dcnt_r  <= '0;
            dneg_r  <= t_r[0][WORD_BITS-1] ^ t_r[1][WORD_BITS-1];
            state_r <= ST_DIV;
          end else begin
            r_r     <= rc;
            nr_r    <= nr_c;
            state_r <= ST_WRITE;
          end
        end
        ST_DIV: begin
          if (dcnt_r == DCW'(WORD_BITS)) begin
            r_r[0]  <= dneg_r ? -quo_r : quo_r;
            nr_r    <= 3'd1;
            state_r <= ST_WRITE;
          end else begin
            dcnt_r <= dcnt_r + DCW'(1);
            if (!rem_diff[WORD_BITS]) begin
              rem_r <= rem_diff[WORD_BITS-1:0];
              quo_r <= {quo_r[WORD_BITS-2:0], 1'b1};
            end else begin
              rem_r <= rem_sh[WORD_BITS-1:0];
              quo_r <= {quo_r[WORD_BITS-2:0], 1'b0};
            end
          end
        end
        ST_WRITE: begin
          if (idx_r < nr_r) begin
            idx_r <= idx_r + 3'd1;
          end else begin
            cnt_r <= base_r + CW'(nr_r);
            if (act_r == ACT_POP) begin
              state_r <= ST_OUT;
            end else if (nr_r == 3'd0) begin
              state_r <= ST_TOPRD;
            end else begin
              res_r   <= r_r[nr_r - 3'd1];
              state_r <= ST_OUT;
            end
          end
        end
        ST_TOPRD: begin
          state_r <= ST_TOPWT;
        end
        ST_TOPWT: begin
          res_r   <= (cnt_r != '0 && act_r != ACT_POP) ? mem_q_r : '0;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r             <= 1'b1;
            out_data_r.status       <= sts_r;
            out_data_r.result_value <= res_r;
            out_data_r.depth        <= 7'(cnt_r);
            state_r                 <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `FDS_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> (cnt_r == '0 && !out_valid_r), "reset left items")
  `FDS_ASSERT(a_cnt_bound, cnt_r <= CW'(DEPTH), "entry count beyond stack depth")
  `FDS_ASSERT(a_wr_bound, we |-> (wr_full < CW'(DEPTH)), "stack write beyond depth")
  `FDS_ASSERT(a_out_src, $rose(out_valid_r) |-> $past(state_r) == ST_OUT,
    "result shown without a finished item")
  `FDS_ASSERT(a_no_rw, !(rd_en && we), "stack read and write in the same cycle")

endmodule

### tb/forth_data_stack_unit_tb.sv
// Self-checking testbench for the bounded Forth data stack: random and directed actions.
module forth_data_stack_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fds_pkg::*;

  localparam int STACK_SLOTS = 64;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [6:0] cfg_data;

  forth_data_stack_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Predictor state: a private copy of the stack and its capacity.
  logic [31:0] model_words [STACK_SLOTS];
  int unsigned model_count;
  logic [6:0] model_cap;

  in_item_t pending_actions[$];
  out_item_t expected_results[$];
  int errors;
  int unsigned cycle_count;
  bit drive_idle_free;
  bit recv_idle_free;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the result of one action and update the predicted stack.
  function automatic out_item_t predict_stack_action(in_item_t item);
    out_item_t r;
    logic [31:0] t [4];
    logic [31:0] w [6];
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    int unsigned need;
    int unsigned grow;
    int unsigned cap;
    int unsigned nw;
    bit popped;
    r.status = STS_OK;
    r.result_value = '0;
    popped = 1'b0;
    nw = 0;
    cap = (model_cap < STACK_SLOTS) ? model_cap : STACK_SLOTS;
    if (item.action <= ACT_GT) begin
      case (item.action)
        ACT_PUSH: need = 0;
        ACT_POP, ACT_TOP, ACT_DUP, ACT_DROP: need = 1;
        ACT_ROT: need = 3;
        ACT_2SWAP, ACT_2OVER: need = 4;
        default: need = 2;
      endcase
      case (item.action)
        ACT_PUSH, ACT_DUP, ACT_OVER: grow = 1;
        ACT_2DUP, ACT_2OVER: grow = 2;
        default: grow = 0;
      endcase
      if (model_count < need) begin
        r.status = STS_FEW;
      end else if (grow > 0 && model_count + grow > cap) begin
        r.status = STS_FULL;
      end else begin
        for (int i = 0; i < 4; i++) begin
          t[i] = (i < need) ? model_words[model_count - 1 - i] : '0;
        end
        a = t[1];
        b = t[0];
        if (item.action == ACT_DIV && b == 0) begin
          r.status = STS_DIV0;
        end else begin
          case (item.action)
            ACT_PUSH: begin w[0] = item.push_value; nw = 1; end
            ACT_POP: begin r.result_value = t[0]; popped = 1'b1; end
            ACT_TOP: begin w[0] = t[0]; nw = 1; end
            ACT_DUP: begin w[0] = t[0]; w[1] = t[0]; nw = 2; end
            ACT_SWAP: begin w[0] = t[0]; w[1] = t[1]; nw = 2; end
            ACT_DROP, ACT_2DROP: nw = 0;
            ACT_OVER: begin w[0] = t[1]; w[1] = t[0]; w[2] = t[1]; nw = 3; end
            ACT_ROT: begin w[0] = t[1]; w[1] = t[0]; w[2] = t[2]; nw = 3; end
            ACT_2SWAP: begin
              w[0] = t[1]; w[1] = t[0]; w[2] = t[3]; w[3] = t[2]; nw = 4;
            end
            ACT_2DUP: begin
              w[0] = t[1]; w[1] = t[0]; w[2] = t[1]; w[3] = t[0]; nw = 4;
            end
            ACT_2OVER: begin
              w[0] = t[3]; w[1] = t[2]; w[2] = t[1]; w[3] = t[0];
              w[4] = t[3]; w[5] = t[2]; nw = 6;
            end
            ACT_ADD: begin w[0] = a + b; nw = 1; end
            ACT_SUB: begin w[0] = a - b; nw = 1; end
            ACT_MUL: begin w[0] = a * b; nw = 1; end
            ACT_DIV: begin
              // Truncating division on magnitudes; the most negative word over -1 wraps.
              ma = a[31] ? -a : a;
              mb = b[31] ? -b : b;
              q = ma / mb;
              w[0] = (a[31] != b[31]) ? -q : q;
              nw = 1;
            end
            ACT_EQ: begin w[0] = (a == b) ? '1 : '0; nw = 1; end
            ACT_LT: begin w[0] = ($signed(a) < $signed(b)) ? '1 : '0; nw = 1; end
            default: begin w[0] = ($signed(b) < $signed(a)) ? '1 : '0; nw = 1; end
          endcase
          model_count -= need;
          for (int i = 0; i < nw; i++) begin
            model_words[model_count + i] = w[i];
          end
          model_count += nw;
        end
      end
    end
    if (!popped) begin
      if (item.action == ACT_POP) begin
        r.result_value = '0;
      end else begin
        r.result_value = (model_count > 0) ? model_words[model_count - 1] : '0;
      end
    end
    r.depth = 7'(model_count);
    return r;
  endfunction

  // Driver: offers queued items, idling now and then.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_actions.size() > 0 && (drive_idle_free || $urandom_range(99) >= 6)) begin
        in_data <= pending_actions[0];
        expected_results.push_back(predict_stack_action(pending_actions.pop_front()));
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random, or a long hold-off while hold_cycles runs down.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= !recv_idle_free && ($urandom_range(99) < 6);
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        errors++;
      end else begin
        out_item_t exp_r;
        exp_r = expected_results.pop_front();
        if (out_data.status !== exp_r.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, exp_r.status, out_data.status);
          errors++;
        end
        if (out_data.result_value !== exp_r.result_value) begin
          $display("%0t: result_value mismatch, expected %0d, actual %0d",
                   $time, exp_r.result_value, out_data.result_value);
          errors++;
        end
        if (out_data.depth !== exp_r.depth) begin
          $display("%0t: depth mismatch, expected %0d, actual %0d",
                   $time, exp_r.depth, out_data.depth);
          errors++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("forth_data_stack_unit regression: fail");
      $finish;
    end
  end

  function automatic logic [31:0] random_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'($urandom_range(4));
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_action(logic [4:0] act, logic [31:0] val);
    in_item_t it;
    it.action = act;
    it.push_value = val;
    pending_actions.push_back(it);
  endtask

  // Wait until every queued item is accepted and its result checked, then settle.
  task automatic drain();
    while (pending_actions.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_capacity(logic [6:0] value);
    @(posedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_cap = value;
  endtask

  // One phase of random items: rare undefined action codes, else pushes mixed with the other defined actions.
  task automatic random_phase(int n);
    logic [4:0] act;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 4) begin
        act = 5'($urandom_range(19, 31));
      end else if ($urandom_range(99) < 35) begin
        act = ACT_PUSH;
      end else begin
        act = 5'($urandom_range(1, 18));
      end
      queue_action(act, random_word());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    cycle_count = 0;
    drive_idle_free = 1'b0;
    recv_idle_free = 1'b0;
    hold_cycles = 0;
    model_count = 0;
    model_cap = CAP_RESET;
    foreach (model_words[i]) model_words[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every action but push on an empty stack, then the edge values and operators.
    for (int a = 1; a <= 18; a++) queue_action(5'(a), '0);
    queue_action(ACT_PUSH, 32'h8000_0000);
    queue_action(ACT_PUSH, 32'hffff_ffff);
    queue_action(ACT_DIV, '0);
    queue_action(ACT_PUSH, 32'h7fff_ffff);
    queue_action(ACT_PUSH, '0);
    queue_action(ACT_DIV, '0);
    queue_action(5'd31, '0);
    drain();

    // Small capacity: dup, 2dup and random pushes run into the limit.
    write_capacity(7'd3);
    queue_action(ACT_2OVER, '0);
    queue_action(ACT_DUP, '0);
    queue_action(ACT_2DROP, '0);
    queue_action(ACT_2DUP, '0);
    queue_action(ACT_2DUP, '0);
    random_phase(80);
    drain();

    write_capacity(7'd0);
    random_phase(30);
    drain();
    write_capacity(7'd1);
    random_phase(40);
    drain();

    // Long hold-off with no sender gaps, so the block backs up.
    write_capacity(7'd127);
    drive_idle_free = 1'b1;
    hold_cycles = 300;
    random_phase(150);
    drain();
    drive_idle_free = 1'b0;

    write_capacity(7'd64);
    recv_idle_free = 1'b1;
    random_phase(150);
    drain();
    recv_idle_free = 1'b0;

    write_capacity(7'd8);
    random_phase(120);
    drain();
    write_capacity(7'd64);
    random_phase(130);
    drain();

    if (errors == 0) begin
      $display("forth_data_stack_unit regression: pass");
    end else begin
      $display("forth_data_stack_unit regression: fail");
    end
    $finish;
  end

endmodule
